// File: src/e2q_pkg.sv
package e2q_pkg;

  localparam int DEF_ANGLE_WIDTH   = 16;
  localparam int DEF_OUT_FRAC_BITS = 15;

  // internal fixed point: Q2.30
  localparam int          QF     = 30;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] Q_ONE  = 31'h4000_0000;

  // Taylor terms per series
  localparam int TERMS = 6;

  // fold, scale, square, three stages per term, final multiply
  localparam int SC_STAGES   = 3 + 3 * TERMS + 1;
  // pair products, triple products, sums, rounding
  localparam int PROD_STAGES = 4;

  typedef logic [30:0] mag_t;

  typedef struct packed {
    logic neg;
    mag_t mag;
  } sval_t;

  // sine divisors k(k+1), innermost first
  function automatic logic [7:0] sin_div(input int k);
    case (k)
      0:       return 8'd156;
      1:       return 8'd110;
      2:       return 8'd72;
      3:       return 8'd42;
      4:       return 8'd20;
      5:       return 8'd6;
      default: return 8'd1;
    endcase
  endfunction

  // cosine divisors k(k-1), innermost first
  function automatic logic [7:0] cos_div(input int k);
    case (k)
      0:       return 8'd132;
      1:       return 8'd90;
      2:       return 8'd56;
      3:       return 8'd30;
      4:       return 8'd12;
      5:       return 8'd2;
      default: return 8'd1;
    endcase
  endfunction

  // floor(2^32 / sin_div)
  function automatic logic [31:0] sin_recip(input int k);
    case (k)
      0:       return 32'd27531841;
      1:       return 32'd39045157;
      2:       return 32'd59652323;
      3:       return 32'd102261126;
      4:       return 32'd214748364;
      5:       return 32'd715827882;
      default: return 32'd0;
    endcase
  endfunction

  // floor(2^32 / cos_div)
  function automatic logic [31:0] cos_recip(input int k);
    case (k)
      0:       return 32'd32537631;
      1:       return 32'd47721858;
      2:       return 32'd76695844;
      3:       return 32'd143165576;
      4:       return 32'd357913941;
      5:       return 32'd2147483648;
      default: return 32'd0;
    endcase
  endfunction

  // rounded Q2.30 product of two magnitudes
  function automatic mag_t mul_mag(input mag_t a, input mag_t b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << (QF - 1));
    return p[QF+30:QF];
  endfunction

endpackage

// File: src/e2q_sincos.sv
module e2q_sincos #(
  parameter int ANGLE_WIDTH = e2q_pkg::DEF_ANGLE_WIDTH
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output e2q_pkg::sval_t         sin_o,
  output e2q_pkg::sval_t         cos_o
);

  localparam int AW = ANGLE_WIDTH;
  localparam int PW = AW + 31;
  localparam logic [AW-1:0] HALF    = AW'(1) << (AW - 1);
  localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);
  localparam int NSD = 3 * e2q_pkg::TERMS + 1;

  typedef struct packed {
    logic        neg;
    logic        swap;
    logic [29:0] x;
    logic [29:0] xsq;
  } side_t;

  // octant fold
  logic          neg_a;
  logic          swap_a;
  logic [AW-1:0] u_a;
  logic [AW-2:0] v_a;

  always_comb begin
    neg_a  = angle[AW-1];
    u_a    = neg_a ? (~angle + 1'b1) : angle;
    swap_a = u_a > QUARTER;
    v_a    = swap_a ? (AW-1)'(HALF - u_a) : u_a[AW-2:0];
  end

  logic          neg1_r, swap1_r;
  logic [AW-2:0] v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= neg_a;
      swap1_r <= swap_a;
      v1_r    <= v_a;
    end
  end

  // half angle in radians, Q30
  logic [PW-1:0] xprod;
  logic          neg2_r, swap2_r;
  logic [29:0]   x2_r;

  assign xprod = PW'(v1_r) * PW'(e2q_pkg::PI_Q30) + PW'(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= neg1_r;
      swap2_r <= swap1_r;
      x2_r    <= xprod[AW+29:AW];
    end
  end

  logic [59:0] sqprod;
  side_t       s3_r;

  assign sqprod = 60'(x2_r) * 60'(x2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.neg  <= neg2_r;
      s3_r.swap <= swap2_r;
      s3_r.x    <= x2_r;
      s3_r.xsq  <= sqprod[59:30];
    end
  end

  side_t               sd  [0:NSD-1];
  e2q_pkg::mag_t       t_s [0:e2q_pkg::TERMS];
  e2q_pkg::mag_t       t_c [0:e2q_pkg::TERMS];

  assign sd[0]  = s3_r;
  assign t_s[0] = e2q_pkg::Q_ONE;
  assign t_c[0] = e2q_pkg::Q_ONE;

  // Horner steps: t = 1 - (x^2 * t) / d, three stages each
  for (genvar i = 0; i < e2q_pkg::TERMS; i++) begin : g_term
    logic [60:0]   ms, mc;
    logic [61:0]   rs, rc;
    logic [29:0]   rem_s, rem_c;
    logic [29:0]   q_s, q_c;
    side_t         sa_r, sb_r, sc_r;
    logic [29:0]   ps_r, pc_r, psb_r, pcb_r, qs_r, qc_r;
    e2q_pkg::mag_t tsn_r, tcn_r;

    assign ms = 61'(sd[3*i].xsq) * 61'(t_s[i]);
    assign mc = 61'(sd[3*i].xsq) * 61'(t_c[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        sa_r <= sd[3*i];
        ps_r <= ms[59:30];
        pc_r <= mc[59:30];
      end
    end

    // reciprocal estimate, low by at most one
    assign rs = 62'(ps_r) * 62'(e2q_pkg::sin_recip(i));
    assign rc = 62'(pc_r) * 62'(e2q_pkg::cos_recip(i));

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r  <= sa_r;
        psb_r <= ps_r;
        pcb_r <= pc_r;
        qs_r  <= rs[61:32];
        qc_r  <= rc[61:32];
      end
    end

    always_comb begin
      rem_s = psb_r - 30'(38'(qs_r) * 38'(e2q_pkg::sin_div(i)));
      rem_c = pcb_r - 30'(38'(qc_r) * 38'(e2q_pkg::cos_div(i)));
      q_s   = qs_r + 30'(rem_s >= 30'(e2q_pkg::sin_div(i)));
      q_c   = qc_r + 30'(rem_c >= 30'(e2q_pkg::cos_div(i)));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sc_r  <= sb_r;
        tsn_r <= e2q_pkg::Q_ONE - 31'(q_s);
        tcn_r <= e2q_pkg::Q_ONE - 31'(q_c);
      end
    end

    assign sd[3*i+1] = sa_r;
    assign sd[3*i+2] = sb_r;
    assign sd[3*i+3] = sc_r;
    assign t_s[i+1]  = tsn_r;
    assign t_c[i+1]  = tcn_r;
  end

  // sin = x * series, then undo the octant fold
  logic [60:0]   fprod;
  e2q_pkg::mag_t tsx;
  side_t         sl;

  assign sl    = sd[NSD-1];
  assign fprod = 61'(sl.x) * 61'(t_s[e2q_pkg::TERMS]);
  assign tsx   = fprod[60:30];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o.neg <= sl.neg;
      sin_o.mag <= sl.swap ? t_c[e2q_pkg::TERMS] : tsx;
      cos_o.neg <= 1'b0;
      cos_o.mag <= sl.swap ? tsx : t_c[e2q_pkg::TERMS];
    end
  end

endmodule

// File: src/euler_angles_to_quaternion_core.sv
// Euler x-y-z angles to unit quaternion.
//
// Input channel (in_*): one word carries roll, pitch and yaw as signed
// binary angles, full scale +/-180 degrees. Output channel (out_*): one
// word carries w, x, y, z in Q1.OUT_FRAC_BITS, rounded and saturated, so
// 1.0 comes out as the largest positive code.
//
// From input handshake to output, a word passes 22 stages in the half-angle
// sine/cosine units (fold, scale, square, three stages for each of six
// Taylor terms, final multiply), then pair products, triple products, sums
// and rounding. Throughput is one word per cycle while the output word is
// not held by a low out_tready.
//
// The pipeline moves as one: when the output word is held by a low
// out_tready, every stage freezes and in_tready drops, so no word is lost
// or repeated. Bubbles advance whenever the output stage is empty.
// Reset clears all valid bits; the datapath registers are not reset.
module euler_angles_to_quaternion_core #(
  parameter int ANGLE_WIDTH   = e2q_pkg::DEF_ANGLE_WIDTH,
  parameter int OUT_FRAC_BITS = e2q_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // roll_angle, pitch_angle, yaw_angle
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [((4*(OUT_FRAC_BITS+1)+7)/8)*8-1:0] out_tdata
);

  localparam int AW     = ANGLE_WIDTH;
  localparam int OW     = OUT_FRAC_BITS + 1;
  localparam int OUT_DW = ((4*OW+7)/8)*8;
  localparam int SC     = e2q_pkg::SC_STAGES;
  localparam int NST    = e2q_pkg::SC_STAGES + e2q_pkg::PROD_STAGES;
  localparam int SH     = e2q_pkg::QF - OUT_FRAC_BITS;
  localparam logic [32:0] RND = 33'd1 << (SH - 1);
  localparam logic [32:0] LIM = 33'd1 << OUT_FRAC_BITS;

  logic           en;
  logic [NST-1:0] vld_r;

  assign en         = !vld_r[NST-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // half-angle sine/cosine per axis
  e2q_pkg::sval_t sr, cr, sp, cp, sy, cy;

  e2q_sincos #(.ANGLE_WIDTH(AW)) u_roll (
    .clk(clk), .en(en), .angle(in_tdata[AW-1:0]), .sin_o(sr), .cos_o(cr)
  );
  e2q_sincos #(.ANGLE_WIDTH(AW)) u_pitch (
    .clk(clk), .en(en), .angle(in_tdata[2*AW-1:AW]), .sin_o(sp), .cos_o(cp)
  );
  e2q_sincos #(.ANGLE_WIDTH(AW)) u_yaw (
    .clk(clk), .en(en), .angle(in_tdata[3*AW-1:2*AW]), .sin_o(sy), .cos_o(cy)
  );

  function automatic e2q_pkg::sval_t smul(input e2q_pkg::sval_t a,
                                          input e2q_pkg::sval_t b);
    e2q_pkg::sval_t r;
    r.neg = a.neg ^ b.neg;
    r.mag = e2q_pkg::mul_mag(a.mag, b.mag);
    return r;
  endfunction

  function automatic logic signed [32:0] sx(input e2q_pkg::sval_t v);
    logic signed [32:0] m;
    m = $signed({2'b00, v.mag});
    return v.neg ? -m : m;
  endfunction

  // round half away from zero, saturate
  function automatic logic [OW-1:0] to_out(input logic signed [32:0] v);
    logic        n;
    logic [32:0] m, r;
    n = v[32];
    m = n ? 33'(-v) : 33'(v);
    r = (m + RND) >> SH;
    if (n) begin
      if (r > LIM) begin
        r = LIM;
      end
      return OW'(~r + 33'd1);
    end
    if (r > LIM - 33'd1) begin
      r = LIM - 33'd1;
    end
    return r[OW-1:0];
  endfunction

  // pair products
  e2q_pkg::sval_t cc_r, ss_r, sc_r, cs_r, cy_r, sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= smul(cr, cp);
      ss_r <= smul(sr, sp);
      sc_r <= smul(sr, cp);
      cs_r <= smul(cr, sp);
      cy_r <= cy;
      sy_r <= sy;
    end
  end

  // triple products
  e2q_pkg::sval_t w1_r, w2_r, x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= smul(cc_r, cy_r);
      w2_r <= smul(ss_r, sy_r);
      x1_r <= smul(sc_r, cy_r);
      x2_r <= smul(cs_r, sy_r);
      y1_r <= smul(cs_r, cy_r);
      y2_r <= smul(sc_r, sy_r);
      z1_r <= smul(cc_r, sy_r);
      z2_r <= smul(ss_r, cy_r);
    end
  end

  logic signed [32:0] w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= sx(w1_r) + sx(w2_r);
      x_r <= sx(x1_r) - sx(x2_r);
      y_r <= sx(y1_r) + sx(y2_r);
      z_r <= sx(z1_r) - sx(z2_r);
    end
  end

  logic [OUT_DW-1:0] out_data_nxt, out_data_r;

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OW-1:0]      = to_out(w_r);
    out_data_nxt[2*OW-1:OW]   = to_out(x_r);
    out_data_nxt[3*OW-1:2*OW] = to_out(y_r);
    out_data_nxt[4*OW-1:3*OW] = to_out(z_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = out_data_r;

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a held output freezes every stage's valid bit
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // pair products of unit values never exceed one
  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SC] |-> cc_r.mag <= e2q_pkg::Q_ONE && ss_r.mag <= e2q_pkg::Q_ONE
               && sc_r.mag <= e2q_pkg::Q_ONE && cs_r.mag <= e2q_pkg::Q_ONE)
    else $error("pair product out of range");

endmodule

// File: tb/e2q_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the quaternion for each accepted input
// word and compares it with the next accepted output word.
module e2q_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          words_seen
);

  localparam int AW = 16;
  localparam int FB = 15;
  localparam int QB = 30;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  quat_t quat_fifo[$];

  // half-angle sine/cosine, Q2.30
  task automatic half_trig(input logic [AW-1:0] a, output longint s, output longint c);
    longint unsigned u, v, xr, x2, ts, tc, sm, cm;
    logic neg, swp;
    longint unsigned sd[6];
    longint unsigned cd[6];
    sd = '{156, 110, 72, 42, 20, 6};
    cd = '{132, 90, 56, 30, 12, 2};
    neg = a[AW-1];
    u = neg ? ((64'd1 << AW) - a) : a;
    swp = u > (64'd1 << (AW - 2));
    v = swp ? ((64'd1 << (AW - 1)) - u) : u;
    xr = (v * 64'd3373259426 + (64'd1 << (AW - 1))) >> AW;
    x2 = (xr * xr) >> QB;
    ts = 64'd1 << QB;
    tc = 64'd1 << QB;
    for (int i = 0; i < 6; i++) begin
      ts = (64'd1 << QB) - ((x2 * ts) >> QB) / sd[i];
      tc = (64'd1 << QB) - ((x2 * tc) >> QB) / cd[i];
    end
    ts = (xr * ts) >> QB;
    sm = swp ? tc : ts;
    cm = swp ? ts : tc;
    s = neg ? -longint'(sm) : longint'(sm);
    c = longint'(cm);
  endtask

  function automatic longint qmul(longint a, longint b);
    longint unsigned ma, mb, p;
    logic n;
    n = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + (64'd1 << (QB - 1))) >> QB;
    return n ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] round_sat(longint v);
    longint unsigned m, r;
    m = v < 0 ? -v : v;
    r = (m + (64'd1 << (QB - FB - 1))) >> (QB - FB);
    if (v < 0) begin
      if (r > (64'd1 << FB)) r = 64'd1 << FB;
      return 16'(-r);
    end
    if (r > (64'd1 << FB) - 1) r = (64'd1 << FB) - 1;
    return 16'(r);
  endfunction

  task automatic predict_quat(input logic [47:0] d);
    longint sr, cr, sp, cp, sy, cy;
    quat_t q;
    half_trig(d[15:0], sr, cr);
    half_trig(d[31:16], sp, cp);
    half_trig(d[47:32], sy, cy);
    q.w = round_sat(qmul(qmul(cr, cp), cy) + qmul(qmul(sr, sp), sy));
    q.x = round_sat(qmul(qmul(sr, cp), cy) - qmul(qmul(cr, sp), sy));
    q.y = round_sat(qmul(qmul(cr, sp), cy) + qmul(qmul(sr, cp), sy));
    q.z = round_sat(qmul(qmul(cr, cp), sy) - qmul(qmul(sr, sp), cy));
    quat_fifo.push_back(q);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    quat_t q;
    if (!rst_n) begin
      fail_count = 0;
      words_seen = 0;
    end else begin
      if (in_tvalid && in_tready) predict_quat(in_tdata);
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (quat_fifo.size() == 0) begin
          $display("%0t: output word with nothing pending", $realtime);
          fail_count++;
        end else begin
          q = quat_fifo.pop_front();
          if (out_tdata[15:0]  !== q.w) report("quat_w", out_tdata[15:0], q.w);
          if (out_tdata[31:16] !== q.x) report("quat_x", out_tdata[31:16], q.x);
          if (out_tdata[47:32] !== q.y) report("quat_y", out_tdata[47:32], q.y);
          if (out_tdata[63:48] !== q.z) report("quat_z", out_tdata[63:48], q.z);
        end
      end
    end
    pending = quat_fifo.size();
  end

endmodule

// File: tb/tb_euler_angles_to_quaternion_core.sv
`timescale 1ns / 1ps

module tb_euler_angles_to_quaternion_core;

  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // roll, pitch, yaw
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // w, x, y, z
  int          fail_count, pending, words_seen;
  int          idle_cycles;
  logic        no_stall;
  logic [15:0] corner[6];

  euler_angles_to_quaternion_core u_dut (.*);

  e2q_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // sink stalls at random, with a chance of 32 in 100, except in a quiet stretch
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      out_tready <= no_stall || ($urandom_range(99) >= 32);
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired, %0d words pending", pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [47:0] d);
    while (!no_stall && $urandom_range(99) < 32) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    no_stall = 0;
    corner = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h0001};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: zero, -180, +max, +/-90, smallest step, mixed
    for (int i = 0; i < 6; i++) send_word({3{corner[i]}});
    for (int i = 0; i < 6; i++)
      send_word({corner[(i + 2) % 6], corner[(i + 1) % 6], corner[i]});
    send_word({16'hffff, 16'h2000, 16'he000});
    send_word({16'h4001, 16'h3fff, 16'hbfff});
    for (int n = 0; n < N_RANDOM; n++) begin
      no_stall = (n >= 400 && n < 600);
      if ($urandom_range(9) == 0)
        send_word({corner[$urandom_range(5)], corner[$urandom_range(5)],
                   corner[$urandom_range(5)]});
      else
        send_word({16'($urandom), 16'($urandom), 16'($urandom)});
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d angle triples incl. corner angles, checked %0d quaternions",
             N_RANDOM + 14, words_seen);
    $display("both channels stalled at random, with one stall-free stretch");
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
src/e2q_pkg.sv
src/e2q_sincos.sv
src/euler_angles_to_quaternion_core.sv
tb/e2q_checker.sv
tb/tb_euler_angles_to_quaternion_core.sv
